@@ rtl/lru_pkg.sv @@
// Package for the LRU cache lookup/insert unit.
// Request and response structs, command codes. No dependencies.
package lru_pkg;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam int EXT_WIDTH = 64;

  typedef logic [EXT_WIDTH-1:0] ext_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] key;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_data;
    logic        duplicate;
  } rsp_t;

endpackage

@@ rtl/lru_cell.sv @@
// One entry of the recency-ordered cell row: key, data and valid flag.
// Loads its neighbour's entry on shift and compares its key with the lookup key.
// No package dependencies.
module lru_cell #(
  parameter int KEY_WIDTH  = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  logic [KEY_WIDTH-1:0]  prev_key,
  input  logic [DATA_WIDTH-1:0] prev_data,
  input  logic                  prev_valid,
  input  logic [KEY_WIDTH-1:0]  lookup_key,
  output logic [KEY_WIDTH-1:0]  key,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  valid,
  output logic                  match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key  <= prev_key;
      data <= prev_data;
    end
  end

  assign match = valid && (key == lookup_key);

endmodule

@@ rtl/lru_cache_lookup_insert_unit.sv @@
// Top level of the fully associative LRU cache lookup/insert unit.
// Uses lru_pkg (request/response types, command codes) and lru_cell.
//
// A request is taken into a holding register and resolved from there by a
// parallel key compare along a row of CAPACITY cells kept in recency order: cell 0
// is the most recent entry, the last cell the least recent one. A get hit moves
// the matching entry to cell 0 and shifts the cells in front of it back by one; a
// put of an absent key shifts the whole row and drops the last cell's entry. Each
// response is registered from the compare on the held request, and the unit
// accepts one request per cycle while the response side keeps up; the single
// compare-and-shift pass over the cell row sets that figure. Empty cells always
// sit at the back of the row, so free entries are filled before any valid one is
// evicted.
module lru_cache_lookup_insert_unit #(
  parameter int CAPACITY   = 8,
  parameter int KEY_WIDTH  = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lru_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lru_pkg::rsp_t rsp
);

  lru_pkg::req_t         held;
  logic                  held_valid;
  logic                  advance;
  logic                  process;

  lru_pkg::ext_t         key_ext;
  lru_pkg::ext_t         data_ext;
  lru_pkg::ext_t         hit_ext;
  logic [KEY_WIDTH-1:0]  lookup_key;
  logic [DATA_WIDTH-1:0] put_data;

  logic [KEY_WIDTH-1:0]  cell_key   [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
  logic [CAPACITY-1:0]   cell_valid;
  logic [CAPACITY-1:0]   match;
  logic [CAPACITY-1:0]   shift;
  logic [CAPACITY-1:0]   ones;
  logic                  any_hit;
  logic [DATA_WIDTH-1:0] hit_data;
  logic [DATA_WIDTH-1:0] front_data;
  lru_pkg::rsp_t         rsp_next;

  assign advance   = !rsp_valid || !rsp_stall;
  assign process   = held_valid && advance;
  assign req_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      held_valid <= 1'b1;
    end else if (process) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      held <= req;
    end
  end

  assign key_ext    = lru_pkg::ext_t'(held.key);
  assign data_ext   = lru_pkg::ext_t'(held.write_data);
  assign lookup_key = key_ext[KEY_WIDTH-1:0];
  assign put_data   = data_ext[DATA_WIDTH-1:0];

  assign any_hit = |match;
  assign ones    = '1;

  always_comb begin
    hit_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_data = hit_data | (match[i] ? cell_data[i] : '0);
    end
  end

  // get hit: cells up to the hit shift back; put miss: whole row shifts
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      shift[i] = 1'b0;
      if (process) begin
        if (held.cmd == lru_pkg::CMD_GET) begin
          shift[i] = |(match & (ones << i));
        end else begin
          shift[i] = !any_hit;
        end
      end
    end
  end

  assign front_data = (held.cmd == lru_pkg::CMD_PUT) ? put_data : hit_data;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_front
      lru_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift[g]),
        .prev_key  (lookup_key),
        .prev_data (front_data),
        .prev_valid(1'b1),
        .lookup_key(lookup_key),
        .key       (cell_key[g]),
        .data      (cell_data[g]),
        .valid     (cell_valid[g]),
        .match     (match[g])
      );
    end else begin : g_rest
      lru_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift[g]),
        .prev_key  (cell_key[g-1]),
        .prev_data (cell_data[g-1]),
        .prev_valid(cell_valid[g-1]),
        .lookup_key(lookup_key),
        .key       (cell_key[g]),
        .data      (cell_data[g]),
        .valid     (cell_valid[g]),
        .match     (match[g])
      );
    end
  end

  assign hit_ext = lru_pkg::ext_t'(hit_data);

  always_comb begin
    rsp_next           = '0;
    rsp_next.hit       = (held.cmd == lru_pkg::CMD_GET) && any_hit;
    rsp_next.duplicate = (held.cmd == lru_pkg::CMD_PUT) && any_hit;
    if (rsp_next.hit) begin
      rsp_next.read_data = hit_ext[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      rsp <= rsp_next;
    end
  end

  // keys of valid cells are unique
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> $onehot0(match))
    else $error("more than one cell matched the request key");

  // valid cells form an unbroken run from the front of the row
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, cell_valid} + {{CAPACITY{1'b0}}, 1'b1}))
    else $error("empty cell in front of a valid one");

  // an accepted insert lands in the front cell
  a_put_front: assert property (@(posedge clk) disable iff (rst)
    (process && held.cmd == lru_pkg::CMD_PUT && !any_hit) |=>
      (cell_valid[0] && cell_key[0] == $past(lookup_key)))
    else $error("insert not placed in the front cell");

endmodule

@@ tb/lru_cache_lookup_insert_unit_test.sv @@
// Testbench for lru_cache_lookup_insert_unit: directed and random get/put requests,
// each response checked against an in-bench LRU cache predictor.
// Depends on lru_pkg and the unit itself.
module lru_cache_lookup_insert_unit_test;

  localparam int CAPACITY  = 8;
  localparam int POOL_SIZE = 12;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  lru_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  lru_pkg::rsp_t rsp;

  logic [31:0] slot_key   [CAPACITY];
  logic [31:0] slot_data  [CAPACITY];
  logic        slot_valid [CAPACITY];
  logic [2:0]  slot_rank  [CAPACITY];
  logic [31:0] key_pool   [POOL_SIZE];

  lru_pkg::rsp_t pending_rsp [$];
  int   error_count   = 0;
  int   send_idle_pct = 0;
  int   rsp_stall_pct = 0;

  lru_cache_lookup_insert_unit #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (32),
    .DATA_WIDTH(32)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_cache_model();
    for (int j = 0; j < CAPACITY; j++) begin
      slot_key[j]   = '0;
      slot_data[j]  = '0;
      slot_valid[j] = 1'b0;
      slot_rank[j]  = 3'(j);
    end
  endfunction

  // rank 0 is most recent; slots ahead of s drop back one place
  function automatic void make_recent(int s);
    logic [2:0] r;
    r = slot_rank[s];
    for (int j = 0; j < CAPACITY; j++)
      if (slot_rank[j] < r) slot_rank[j] = slot_rank[j] + 3'd1;
    slot_rank[s] = '0;
  endfunction

  function automatic lru_pkg::rsp_t predict_access(lru_pkg::req_t r);
    lru_pkg::rsp_t res;
    int   found;
    int   victim;
    res   = '0;
    found = -1;
    for (int j = 0; j < CAPACITY; j++)
      if (found < 0 && slot_valid[j] && slot_key[j] == r.key) found = j;
    if (r.cmd == lru_pkg::CMD_GET) begin
      if (found >= 0) begin
        res.hit       = 1'b1;
        res.read_data = slot_data[found];
        make_recent(found);
      end
    end else if (found >= 0) begin
      res.duplicate = 1'b1;
    end else begin
      victim = 0;
      for (int j = 0; j < CAPACITY; j++)
        if (slot_rank[j] == 3'(CAPACITY - 1)) victim = j;
      slot_key[victim]   = r.key;
      slot_data[victim]  = r.write_data;
      slot_valid[victim] = 1'b1;
      make_recent(victim);
    end
    return res;
  endfunction

  function automatic lru_pkg::req_t make_req(logic cmd, logic [31:0] key, logic [31:0] data);
    lru_pkg::req_t r;
    r.cmd        = cmd;
    r.key        = key;
    r.write_data = data;
    return r;
  endfunction

  // entered and left at a falling edge; valid stays high for a back-to-back request
  task automatic send_request(input lru_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_rsp.push_back(predict_access(r));
    @(negedge clk);
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) rsp_stall <= ($urandom_range(99) < rsp_stall_pct);

  always @(posedge clk) begin
    lru_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding");
        error_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.hit !== want.hit) begin
          $error("hit mismatch: expected %0d, actual %0d", want.hit, rsp.hit);
          error_count++;
        end
        if (rsp.read_data !== want.read_data) begin
          $error("read_data mismatch: expected %08h, actual %08h",
                 want.read_data, rsp.read_data);
          error_count++;
        end
        if (rsp.duplicate !== want.duplicate) begin
          $error("duplicate mismatch: expected %0d, actual %0d",
                 want.duplicate, rsp.duplicate);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_lookup();
    send_request(make_req(lru_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000));
    send_request(make_req(lru_pkg::CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_field_extremes();
    send_request(make_req(lru_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0000));
    send_request(make_req(lru_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(lru_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000));
    send_request(make_req(lru_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000));
    // write data must be ignored on a get
    send_request(make_req(lru_pkg::CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF));
  endtask

  task automatic test_duplicate_insert();
    send_request(make_req(lru_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h1234_5678));
    send_request(make_req(lru_pkg::CMD_PUT, 32'h0000_0000, 32'hA5A5_A5A5));
    send_request(make_req(lru_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000));
  endtask

  task automatic test_fill_and_evict();
    for (int k = 1; k <= CAPACITY; k++)
      send_request(make_req(lru_pkg::CMD_PUT, 32'(k), 32'h100 + 32'(k)));
    // the two oldest entries are gone by now
    send_request(make_req(lru_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000));
    send_request(make_req(lru_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000));
  endtask

  task automatic test_recency_update();
    send_request(make_req(lru_pkg::CMD_GET, 32'd1, 32'h0));
    send_request(make_req(lru_pkg::CMD_PUT, 32'd100, 32'hDEAD_BEEF));
    send_request(make_req(lru_pkg::CMD_PUT, 32'd101, 32'hCAFE_F00D));
    send_request(make_req(lru_pkg::CMD_GET, 32'd1, 32'h0));
    send_request(make_req(lru_pkg::CMD_GET, 32'd2, 32'h0));
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    logic [31:0] key_val;
    logic        cmd_val;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    for (int k = 0; k < POOL_SIZE; k++) key_pool[k] = $urandom();
    repeat (count) begin
      // a small key pool keeps hits, duplicates and evictions frequent
      if ($urandom_range(99) < 85) begin
        key_val = key_pool[$urandom_range(POOL_SIZE - 1)];
        cmd_val = ($urandom_range(99) < 55) ? lru_pkg::CMD_GET : lru_pkg::CMD_PUT;
      end else begin
        key_val = $urandom();
        cmd_val = ($urandom_range(1) == 0) ? lru_pkg::CMD_GET : lru_pkg::CMD_PUT;
      end
      send_request(make_req(cmd_val, key_val, $urandom()));
    end
    drain_responses();
  endtask

  initial begin
    clear_cache_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_lookup();
    test_field_extremes();
    test_duplicate_insert();
    test_fill_and_evict();
    test_recency_update();
    drain_responses();

    test_random_traffic(256, 0, 0);
    test_random_traffic(256, 55, 0);
    test_random_traffic(256, 0, 55);
    test_random_traffic(256, 19, 19);

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
